// ===== hw/rtl/bqc_pkg.sv =====
package bqc_pkg;

  localparam int SECTIONS   = 2;
  localparam int COEF_WIDTH = 18;
  localparam int FRAC_BITS  = COEF_WIDTH - 2;

  localparam int NUM_W    = 54;
  localparam int DEN_W    = 36;
  localparam int FIELDS_W = 3 * COEF_WIDTH;

  localparam int IN_W     = 16;
  localparam int OUT_W    = 16;
  localparam int SAMPLE_W = 32;
  localparam int OUT_FRAC = 8;
  localparam int PROD_W   = COEF_WIDTH + SAMPLE_W;
  localparam int ACC_W    = PROD_W + 3;

  localparam int SEC_W  = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
  localparam int STEP_W = 3;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 64;

  localparam logic [NUM_W-1:0] NUM_RESET = NUM_W'(64'd1 << FRAC_BITS);
  localparam logic [DEN_W-1:0] DEN_RESET = '0;

  typedef enum logic [1:0] {
    REG_FIRST_NUM,
    REG_FIRST_DEN,
    REG_SECOND_NUM,
    REG_SECOND_DEN
  } reg_idx_e;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  typedef enum logic [2:0] {
    COEF_B0,
    COEF_B1,
    COEF_B2,
    COEF_A1,
    COEF_A2
  } coef_e;

  typedef enum logic [2:0] {
    OPND_X,
    OPND_X1,
    OPND_X2,
    OPND_Y1,
    OPND_Y2
  } opnd_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB
  } acc_op_e;

  typedef enum logic [1:0] {
    BR_NEXT,
    BR_SECTION,
    BR_END
  } br_e;

  typedef struct packed {
    coef_e   coef;
    opnd_e   opnd;
    acc_op_e acc;
    logic    wb;
    br_e     br;
  } ucode_t;

  localparam logic [STEP_W-1:0] STEP_START = '0;

  function automatic ucode_t ucode(input logic [STEP_W-1:0] step);
    ucode_t w;
    w = '{coef: COEF_B0, opnd: OPND_X, acc: ACC_HOLD, wb: 1'b0, br: BR_NEXT};
    unique case (step)
      STEP_W'(0): w = '{coef: COEF_B0, opnd: OPND_X,  acc: ACC_HOLD, wb: 1'b0, br: BR_NEXT};
      STEP_W'(1): w = '{coef: COEF_B1, opnd: OPND_X1, acc: ACC_LOAD, wb: 1'b0, br: BR_NEXT};
      STEP_W'(2): w = '{coef: COEF_B2, opnd: OPND_X2, acc: ACC_ADD,  wb: 1'b0, br: BR_NEXT};
      STEP_W'(3): w = '{coef: COEF_A1, opnd: OPND_Y1, acc: ACC_ADD,  wb: 1'b0, br: BR_NEXT};
      STEP_W'(4): w = '{coef: COEF_A2, opnd: OPND_Y2, acc: ACC_SUB,  wb: 1'b0, br: BR_NEXT};
      STEP_W'(5): w = '{coef: COEF_B0, opnd: OPND_X,  acc: ACC_SUB,  wb: 1'b0, br: BR_NEXT};
      STEP_W'(6): w = '{coef: COEF_B0, opnd: OPND_X,  acc: ACC_HOLD, wb: 1'b1, br: BR_SECTION};
      STEP_W'(7): w = '{coef: COEF_B0, opnd: OPND_X,  acc: ACC_HOLD, wb: 1'b0, br: BR_END};
      default:    w = '{coef: COEF_B0, opnd: OPND_X,  acc: ACC_HOLD, wb: 1'b0, br: BR_END};
    endcase
    return w;
  endfunction

  function automatic logic signed [COEF_WIDTH-1:0] coef_field(
    input logic [NUM_W-1:0] word,
    input int               k
  );
    logic [FIELDS_W-1:0] padded;
    padded = FIELDS_W'(word);
    return padded[k*COEF_WIDTH +: COEF_WIDTH];
  endfunction

endpackage

// ===== hw/rtl/biquad_cascade_iir_filter.sv =====
// Channel   Direction  Handshake               Payload
// in        input      in_valid_i / in_stall_o  sample_in_i  (16 bit signed)
// out       output     out_valid_o / out_stall_i sample_out_o (16 bit signed)
// cfg       input      APB write (pready high)  pwdata/paddr, 64 bit, regs at 8*i
//
// An item runs seven microcode steps per section on the one shared multiplier
// and accumulator, then one output step. A new item is accepted once the program
// ends, also while a result still waits. The output step holds while the
// previous result is stalled. Reset clears the section history and loads the
// default coefficients.
module biquad_cascade_iir_filter
  import bqc_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [IN_W-1:0]  sample_in_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [OUT_W-1:0] sample_out_o,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ADDR_W-1:0]       paddr,
  input  logic [DATA_W-1:0]       pwdata,
  output logic [DATA_W-1:0]       prdata,
  output logic                    pready
);

  logic [NUM_W-1:0] num1_q, num2_q;
  logic [DEN_W-1:0] den1_q, den2_q;
  reg_idx_e         cfg_idx;
  logic             cfg_wr;

  state_e            state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [SEC_W-1:0]  sec_q, sec_d;
  logic              out_valid_q, out_valid_d;
  logic              accept, sec_last, out_free, load_out;
  ucode_t            uw;

  logic signed [SAMPLE_W-1:0] x1_q [SECTIONS];
  logic signed [SAMPLE_W-1:0] x2_q [SECTIONS];
  logic signed [SAMPLE_W-1:0] y1_q [SECTIONS];
  logic signed [SAMPLE_W-1:0] y2_q [SECTIONS];
  logic signed [SAMPLE_W-1:0] x_q, x_d;

  logic [NUM_W-1:0]             num_sel;
  logic [NUM_W-1:0]             den_sel;
  logic signed [COEF_WIDTH-1:0] coef_s;
  logic signed [SAMPLE_W-1:0]   opnd_s;
  logic signed [PROD_W-1:0]     prod_d, prod_q;
  logic signed [ACC_W-1:0]      acc_d, acc_q, prod_ext, shifted;
  logic [ACC_W-SAMPLE_W:0]      sat_hi;
  logic signed [SAMPLE_W-1:0]   y_new;

  logic signed [SAMPLE_W-1:0]          biased;
  logic signed [SAMPLE_W-OUT_FRAC-1:0] int_part;
  logic [SAMPLE_W-OUT_FRAC-OUT_W:0]    out_hi;
  logic signed [OUT_W-1:0]             out_d, out_q;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_e'(paddr[ADDR_W-1:3]);
  assign cfg_wr  = psel & penable & pwrite;

  always_comb begin
    unique case (cfg_idx)
      REG_FIRST_NUM:  prdata = DATA_W'(num1_q);
      REG_FIRST_DEN:  prdata = DATA_W'(den1_q);
      REG_SECOND_NUM: prdata = DATA_W'(num2_q);
      REG_SECOND_DEN: prdata = DATA_W'(den2_q);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num1_q <= NUM_RESET;
      den1_q <= DEN_RESET;
      num2_q <= NUM_RESET;
      den2_q <= DEN_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_FIRST_NUM:  num1_q <= pwdata[NUM_W-1:0];
        REG_FIRST_DEN:  den1_q <= pwdata[DEN_W-1:0];
        REG_SECOND_NUM: num2_q <= pwdata[NUM_W-1:0];
        REG_SECOND_DEN: den2_q <= pwdata[DEN_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  assign uw          = ucode(step_q);
  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i & ~in_stall_o;
  assign sec_last    = (sec_q == SEC_W'(SECTIONS - 1));
  assign out_free    = ~out_valid_q | ~out_stall_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    sec_d       = sec_q;
    load_out    = 1'b0;
    out_valid_d = out_valid_q & out_stall_i;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_RUN;
          step_d  = STEP_START;
          sec_d   = '0;
        end
      end
      ST_RUN: begin
        unique case (uw.br)
          BR_NEXT: step_d = step_q + STEP_W'(1);
          BR_SECTION: begin
            if (sec_last) begin
              step_d = step_q + STEP_W'(1);
            end else begin
              step_d = STEP_START;
              sec_d  = sec_q + SEC_W'(1);
            end
          end
          BR_END: begin
            if (out_free) begin
              load_out    = 1'b1;
              out_valid_d = 1'b1;
              state_d     = ST_IDLE;
            end
          end
          default: state_d = ST_IDLE;
        endcase
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= STEP_START;
      sec_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      sec_q       <= sec_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath
  assign num_sel = (sec_q == '0) ? num1_q : num2_q;
  assign den_sel = (sec_q == '0) ? NUM_W'(den1_q) : NUM_W'(den2_q);

  always_comb begin
    case (uw.coef)
      COEF_B0: coef_s = coef_field(num_sel, 0);
      COEF_B1: coef_s = coef_field(num_sel, 1);
      COEF_B2: coef_s = coef_field(num_sel, 2);
      COEF_A1: coef_s = coef_field(den_sel, 0);
      COEF_A2: coef_s = coef_field(den_sel, 1);
      default: coef_s = '0;
    endcase
    case (uw.opnd)
      OPND_X:  opnd_s = x_q;
      OPND_X1: opnd_s = x1_q[sec_q];
      OPND_X2: opnd_s = x2_q[sec_q];
      OPND_Y1: opnd_s = y1_q[sec_q];
      OPND_Y2: opnd_s = y2_q[sec_q];
      default: opnd_s = '0;
    endcase
  end

  assign prod_d   = coef_s * opnd_s;
  assign prod_ext = ACC_W'(prod_q);

  always_comb begin
    case (uw.acc)
      ACC_LOAD: acc_d = prod_ext;
      ACC_ADD:  acc_d = acc_q + prod_ext;
      ACC_SUB:  acc_d = acc_q - prod_ext;
      default:  acc_d = acc_q;
    endcase
  end

  assign shifted = acc_q >>> FRAC_BITS;
  assign sat_hi  = shifted[ACC_W-1:SAMPLE_W-1];

  always_comb begin
    if ((&sat_hi) || ~(|sat_hi)) begin
      y_new = shifted[SAMPLE_W-1:0];
    end else if (shifted[ACC_W-1]) begin
      y_new = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      y_new = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  end

  always_comb begin
    x_d = x_q;
    if (accept) begin
      x_d = {{(SAMPLE_W-IN_W-OUT_FRAC){sample_in_i[IN_W-1]}}, sample_in_i,
             {OUT_FRAC{1'b0}}};
    end else if (state_q == ST_RUN && uw.wb) begin
      x_d = y_new;
    end
  end

  assign biased   = x_q[SAMPLE_W-1] ? x_q + SAMPLE_W'((1 << OUT_FRAC) - 1) : x_q;
  assign int_part = biased[SAMPLE_W-1:OUT_FRAC];
  assign out_hi   = int_part[SAMPLE_W-OUT_FRAC-1:OUT_W-1];

  always_comb begin
    if ((&out_hi) || ~(|out_hi)) begin
      out_d = int_part[OUT_W-1:0];
    end else if (int_part[SAMPLE_W-OUT_FRAC-1]) begin
      out_d = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      out_d = {1'b0, {(OUT_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
    x_q    <= x_d;
    if (load_out) begin
      out_q <= out_d;
    end
  end

  assign sample_out_o = out_q;

  // section history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SECTIONS; i++) begin
        x1_q[i] <= '0;
        x2_q[i] <= '0;
        y1_q[i] <= '0;
        y2_q[i] <= '0;
      end
    end else if (state_q == ST_RUN && uw.wb) begin
      x2_q[sec_q] <= x1_q[sec_q];
      x1_q[sec_q] <= x_q;
      y2_q[sec_q] <= y1_q[sec_q];
      y1_q[sec_q] <= y_new;
    end
  end

endmodule

// ===== test/biquad_cascade_iir_filter_tb.sv =====
module biquad_cascade_iir_filter_tb
  import bqc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;
  localparam logic [COEF_WIDTH-1:0] COEF_PEAK  = {1'b0, {(COEF_WIDTH-1){1'b1}}};
  localparam logic [COEF_WIDTH-1:0] COEF_FLOOR = {1'b1, {(COEF_WIDTH-1){1'b0}}};
  localparam int RANDOM_SETTINGS   = 8;
  localparam int ITEMS_PER_SETTING = 235;

  localparam logic signed [IN_W-1:0] PLAIN_SET [10] =
    '{0, 32767, -32768, 1, -1, 21845, -21846, 127, -128, 0};
  localparam logic signed [IN_W-1:0] PEAK_SET [7] =
    '{1, 32767, 32767, -32768, -32768, -1, 0};
  localparam logic signed [IN_W-1:0] FLOOR_SET [7] =
    '{-1, 32767, -32768, 32767, 0, 0, 1};

  typedef enum int {
    STYLE_PASS,
    STYLE_PEAK,
    STYLE_FLOOR,
    STYLE_ZERO,
    STYLE_GENTLE,
    STYLE_WILD
  } coef_style_e;

  class cascade_scoreboard;
    logic [NUM_W-1:0] numer [2];
    logic [DEN_W-1:0] denom [2];
    longint x1 [SECTIONS];
    longint x2 [SECTIONS];
    longint y1 [SECTIONS];
    longint y2 [SECTIONS];
    logic signed [OUT_W-1:0] awaited_samples [$];
    int errors;
    int accepted;
    int checked;
    int clipped;

    function new();
      numer[0] = NUM_RESET;
      numer[1] = NUM_RESET;
      denom[0] = DEN_RESET;
      denom[1] = DEN_RESET;
      for (int s = 0; s < SECTIONS; s++) begin
        x1[s] = 0;
        x2[s] = 0;
        y1[s] = 0;
        y2[s] = 0;
      end
    endfunction

    function void set_register(reg_idx_e idx, logic [DATA_W-1:0] value);
      case (idx)
        REG_FIRST_NUM:  numer[0] = value[NUM_W-1:0];
        REG_FIRST_DEN:  denom[0] = value[DEN_W-1:0];
        REG_SECOND_NUM: numer[1] = value[NUM_W-1:0];
        REG_SECOND_DEN: denom[1] = value[DEN_W-1:0];
        default: ;
      endcase
    endfunction

    function longint coef(logic [63:0] word, int k);
      logic signed [COEF_WIDTH-1:0] c;
      c = word[k*COEF_WIDTH +: COEF_WIDTH];
      return longint'(c);
    endfunction

    function int pending();
      return awaited_samples.size();
    endfunction

    function void note_sample(logic signed [IN_W-1:0] sample);
      longint x;
      longint acc;
      longint y;
      int bank;
      x = longint'(sample) * 256;
      for (int s = 0; s < SECTIONS; s++) begin
        bank = (s == 0) ? 0 : 1;
        acc = coef(numer[bank], 0) * x
            + coef(numer[bank], 1) * x1[s]
            + coef(numer[bank], 2) * x2[s]
            - coef(denom[bank], 0) * y1[s]
            - coef(denom[bank], 1) * y2[s];
        y = acc >>> FRAC_BITS;
        if (y > Q_MAX) y = Q_MAX;
        else if (y < Q_MIN) y = Q_MIN;
        x2[s] = x1[s];
        x1[s] = x;
        y2[s] = y1[s];
        y1[s] = y;
        x = y;
      end
      y = x / 256;
      if (y > 32767) y = 32767;
      else if (y < -32768) y = -32768;
      awaited_samples.push_back(OUT_W'(y));
      accepted++;
    endfunction

    task report(string what);
      $display("[%0t] MISMATCH %s", $realtime, what);
      errors++;
    endtask

    task check_output(logic signed [OUT_W-1:0] got);
      logic signed [OUT_W-1:0] want;
      checked++;
      if (awaited_samples.size() == 0) begin
        report($sformatf("sample_out %0d arrived with no input pending", got));
      end else begin
        want = awaited_samples.pop_front();
        if (want == 16'sh7fff || want == 16'sh8000) clipped++;
        if (got !== want)
          report($sformatf("sample_out #%0d: got %0d, expected %0d", checked, got, want));
      end
    endtask
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic signed [IN_W-1:0]  sample_in_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic signed [OUT_W-1:0] sample_out_o;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [ADDR_W-1:0]       paddr = '0;
  logic [DATA_W-1:0]       pwdata = '0;
  logic [DATA_W-1:0]       prdata;
  logic                    pready;

  cascade_scoreboard board;
  bit burst_mode;
  logic signed [IN_W-1:0] last_sample = '0;
  int settings;

  biquad_cascade_iir_filter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_in_i (sample_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sample_out_o(sample_out_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task automatic write_reg(input reg_idx_e idx, input logic [DATA_W-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 3'b000});
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    board.set_register(idx, value);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic program_section(input int sec, input coef_style_e style);
    logic [DATA_W-1:0] num_word;
    logic [DATA_W-1:0] den_word;
    int b0, b1, b2, a1, a2, reach;
    reg_idx_e num_reg;
    reg_idx_e den_reg;
    num_reg  = (sec == 0) ? REG_FIRST_NUM : REG_SECOND_NUM;
    den_reg  = (sec == 0) ? REG_FIRST_DEN : REG_SECOND_DEN;
    num_word = {$urandom, $urandom};
    den_word = {$urandom, $urandom};
    case (style)
      STYLE_PASS: begin
        num_word[NUM_W-1:0] = NUM_RESET;
        den_word[DEN_W-1:0] = DEN_RESET;
      end
      STYLE_PEAK: begin
        num_word[NUM_W-1:0] = {3{COEF_PEAK}};
        den_word[DEN_W-1:0] = {2{COEF_PEAK}};
      end
      STYLE_FLOOR: begin
        num_word[NUM_W-1:0] = {3{COEF_FLOOR}};
        den_word[DEN_W-1:0] = {2{COEF_FLOOR}};
      end
      STYLE_ZERO: begin
        num_word[NUM_W-1:0] = '0;
        den_word[DEN_W-1:0] = '0;
      end
      STYLE_GENTLE: begin
        b0 = int'($urandom_range(0, 32768)) - 16384;
        b1 = int'($urandom_range(0, 32768)) - 16384;
        b2 = int'($urandom_range(0, 32768)) - 16384;
        a2 = int'($urandom_range(0, 58982));
        reach = ((65536 + a2) * 15) / 16;
        a1 = int'($urandom_range(0, 2 * reach)) - reach;
        num_word[NUM_W-1:0] = {COEF_WIDTH'(b2), COEF_WIDTH'(b1), COEF_WIDTH'(b0)};
        den_word[DEN_W-1:0] = {COEF_WIDTH'(a2), COEF_WIDTH'(a1)};
      end
      default: ;
    endcase
    write_reg(num_reg, num_word);
    write_reg(den_reg, den_word);
  endtask

  function automatic coef_style_e pick_style();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return STYLE_GENTLE;
    if (r < 7) return STYLE_WILD;
    if (r == 7) return STYLE_PASS;
    if (r == 8) return STYLE_ZERO;
    return $urandom_range(0, 1) ? STYLE_PEAK : STYLE_FLOOR;
  endfunction

  function automatic logic signed [IN_W-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) last_sample = IN_W'($urandom);
    else if (r < 7) last_sample = IN_W'(int'($urandom_range(0, 600)) - 300);
    else if (r == 7) last_sample = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    return last_sample;
  endfunction

  task automatic push_sample(input logic signed [IN_W-1:0] sample);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 6);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    sample_in_i <= sample;
    do @(posedge clk_i); while (in_stall_o);
    board.note_sample(sample);
  endtask

  // drop valid and hold until every expected sample is out
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  initial begin : drain_outputs
    int hold_for;
    int held;
    bit taken;
    wait (rst_ni === 1'b1);
    forever begin
      hold_for = burst_mode ? 0 : $urandom_range(0, 6);
      held  = 0;
      taken = 1'b0;
      @(negedge clk_i);
      out_stall_i <= (hold_for != 0);
      while (!taken) begin
        @(posedge clk_i);
        if (out_valid_o && !out_stall_i) begin
          taken = 1'b1;
        end else begin
          if (out_valid_o) held++;
          @(negedge clk_i);
          if (held >= hold_for) out_stall_i <= 1'b0;
        end
      end
      board.check_output(sample_out_o);
    end
  end

  initial begin
    board = new();
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (PLAIN_SET[i]) push_sample(PLAIN_SET[i]);
    settle();
    program_section(0, STYLE_PEAK);
    program_section(1, STYLE_PEAK);
    settings = 2;
    foreach (PEAK_SET[i]) push_sample(PEAK_SET[i]);
    settle();
    program_section(0, STYLE_FLOOR);
    program_section(1, STYLE_FLOOR);
    settings++;
    foreach (FLOOR_SET[i]) push_sample(FLOOR_SET[i]);

    for (int p = 0; p < RANDOM_SETTINGS; p++) begin
      settle();
      program_section(0, pick_style());
      program_section(1, pick_style());
      settings++;
      for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
        if (n % 40 == 0) burst_mode = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 149) == 0) settle();
        push_sample(pick_sample());
      end
    end
    settle();

    $display("Checked %0d of %0d filtered samples over %0d coefficient settings; %0d at the rail.",
             board.checked, board.accepted, settings, board.clipped);
    $display("Stimulus mixed full-scale, small, rail and held inputs under random gaps and stalls.");
    if (board.errors == 0) begin
      $display("** biquad_cascade_iir_filter: PASSED **");
    end else begin
      $display("** biquad_cascade_iir_filter: FAILED **");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("Timeout with %0d samples still expected", board.pending());
    $display("** biquad_cascade_iir_filter: FAILED **");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/bqc_pkg.sv
hw/rtl/biquad_cascade_iir_filter.sv
test/biquad_cascade_iir_filter_tb.sv
